// File: design/hds_pkg.sv
package hds_pkg;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int ROW_W     = 12;
    localparam int COL_W     = 10;
    localparam int FW_W      = 11;
    localparam int GAIN_W    = 2;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    // Internal width for frame-width arithmetic, covers widths up to 4096
    localparam int DIM_W = 13;

    // Smallest frame side that the stencil accepts
    localparam int MIN_DIM = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_GAIN    = 2'd2;

    // Configuration reset values
    localparam logic [FW_W-1:0]   RST_FRAME_WIDTH  = 11'd640;
    localparam logic [ROW_W-1:0]  RST_FRAME_HEIGHT = 12'd480;
    localparam logic [GAIN_W-1:0] RST_DIFF_GAIN    = 2'd1;

    typedef logic [PIX_W-1:0] pix_t;

    // Control of one window tap cell
    typedef struct packed {
        logic shift;
        logic seed;
    } tap_ctl_t;

endpackage

// File: design/hds_ram.sv
module hds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port, read returns the old data on a collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/hds_tap_cell.sv
module hds_tap_cell
    import hds_pkg::*;
(
    input  logic     clk,
    input  tap_ctl_t ctl,
    input  pix_t     seed_pix,
    input  pix_t     nbr_pix,
    output pix_t     tap
);

    pix_t tap_reg;

    // Take the neighbor's pixel on each item, or the row-start seed
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            tap_reg <= ctl.seed ? seed_pix : nbr_pix;
        end
    end

    assign tap = tap_reg;

endmodule

// File: design/heat_diffusion_stencil_pass_top.sv
// An accepted item is captured in the stencil stage registers and its first result then moves
// to the output register once that is free; a second result of the same item follows it.
// Throughput: one item per cycle while the output is not stalled; an interior item of the
// bottom row yields two results and so holds the input while the single output register takes the first.
// The line store is two RAM banks of MAX_WIDTH pixels, both read and one written per item.
// Reset: position counters to (0,0), 640 x 480 frame, gain 1; the line store is not
// cleared and holds no data until written, so no clearing pass follows reset.
module heat_diffusion_stencil_pass_top
    import hds_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PIX_W-1:0]     pixel_in,
    input  logic                 frame_start,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ROW_W-1:0]     out_row,
    output logic [COL_W-1:0]     out_col,
    output logic [PIX_W-1:0]     pixel_out,
    output logic                 last_of_run,
    output logic                 frame_done
);

    localparam int CW       = $clog2(MAX_WIDTH + 1);
    localparam int AW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int NUM_TAPS = 2;
    localparam int LAP_W    = PIX_W + 3;
    localparam int VAL_W    = PIX_W + 6;

    // Configuration registers
    logic [FW_W-1:0]   frame_width_reg;
    logic [ROW_W-1:0]  frame_height_reg;
    logic [GAIN_W-1:0] gain_reg;

    // Position counters
    logic [CW-1:0]    col_reg;
    logic [ROW_W-1:0] row_reg;

    // Row-start pixel of each bank
    pix_t first_pix_reg [2];

    // Stencil stage
    logic             s1_pend_int_reg;
    logic             s1_pend_bord_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    pix_t             s1_pix_reg;
    logic             s1_ybit_reg;
    logic             s1_done_reg;

    // Output register
    logic             o_valid_reg;
    logic [ROW_W-1:0] o_row_reg;
    logic [COL_W-1:0] o_col_reg;
    pix_t             o_pix_reg;
    logic             o_last_reg;
    logic             o_done_reg;

    logic [DIM_W-1:0]  fw_ext;
    logic [DIM_W-1:0]  w_wide;
    logic [CW-1:0]     w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic [CW-1:0]     c0;
    logic [ROW_W-1:0]  r0;
    logic              col_wrap;
    logic [ROW_W:0]    r1;
    logic [ROW_W-1:0]  y;
    logic [CW-1:0]     x;
    logic [CW-1:0]     x_p1;
    logic              last_col;
    logic              last_row;
    logic              int_en;
    logic              bord_en;
    logic              ybit;
    logic [CW-1:0]     col_next;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W+CW-1:0] col_ext;
    logic              in_acc;

    pix_t              ram_q [2];
    pix_t              tap_q [NUM_TAPS];
    tap_ctl_t          tap_ctl [NUM_TAPS];
    pix_t              up_pix;
    pix_t              right_pix;
    pix_t              ctr_pix;
    pix_t              left_pix;

    logic [PIX_W+1:0]        nsum;
    logic signed [LAP_W-1:0] lap;
    logic signed [VAL_W-1:0] lap_x;
    logic signed [VAL_W-1:0] term;
    logic signed [VAL_W-1:0] val;
    pix_t                    sat_pix;

    logic o_free;
    logic s1_any;
    logic move;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            gain_reg         <= RST_DIFF_GAIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[ROW_W-1:0];
                REG_DIFF_GAIN:    gain_reg         <= cfg_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp frame dimensions
    always_comb
    begin
        fw_ext = DIM_W'(frame_width_reg);
        if (fw_ext < DIM_W'(MIN_DIM))
        begin
            w_wide = DIM_W'(MIN_DIM);
        end
        else if (fw_ext > DIM_W'(MAX_WIDTH))
        begin
            w_wide = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            w_wide = fw_ext;
        end
        w_eff = w_wide[CW-1:0];
        h_eff = (frame_height_reg < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : frame_height_reg;
    end

    // Place the incoming item and classify it
    always_comb
    begin
        c0       = frame_start ? '0 : col_reg;
        r0       = frame_start ? '0 : row_reg;
        col_wrap = (c0 >= w_eff);
        r1       = {1'b0, r0} + {{ROW_W{1'b0}}, col_wrap};
        y        = (r1 >= {1'b0, h_eff}) ? '0 : r1[ROW_W-1:0];
        x        = col_wrap ? '0 : c0;
        x_p1     = x + CW'(1);
        last_col = (x_p1 == w_eff);
        last_row = (y == h_eff - ROW_W'(1));
        int_en   = (y >= ROW_W'(2)) && (x != '0) && !last_col;
        bord_en  = (y == '0) || last_row || (x == '0) || last_col;
        ybit     = y[0];
        col_next = last_col ? '0 : x_p1;
        row_next = last_col ? (last_row ? '0 : y + ROW_W'(1)) : y;
        col_ext  = {{COL_W{1'b0}}, x};
    end

    assign in_acc = in_valid && in_ready;

    // Advance position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Keep the first pixel of each row for the left tap
    always_ff @(posedge clk)
    begin
        if (in_acc && (x == '0))
        begin
            first_pix_reg[ybit] <= pixel_in;
        end
    end

    // Line store banks: own bank gives the pixel above, other bank the one to the right
    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        hds_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_bank (
            .clk   (clk),
            .we    (in_acc && (ybit == 1'(b))),
            .waddr (x[AW-1:0]),
            .wdata (pixel_in),
            .re    (in_acc),
            .raddr ((ybit == 1'(b)) ? x[AW-1:0] : x_p1[AW-1:0]),
            .rdata (ram_q[b])
        );
    end

    assign up_pix    = ram_q[s1_ybit_reg];
    assign right_pix = ram_q[~s1_ybit_reg];

    // Window taps of the middle row: center, then left
    for (genvar i = 0; i < NUM_TAPS; i++)
    begin : g_tap
        always_comb
        begin
            tap_ctl[i].shift = in_acc;
            tap_ctl[i].seed  = (i == NUM_TAPS - 1) && (x == CW'(1));
        end

        if (i == 0)
        begin : g_head
            hds_tap_cell u_cell (
                .clk      (clk),
                .ctl      (tap_ctl[i]),
                .seed_pix (first_pix_reg[~ybit]),
                .nbr_pix  (right_pix),
                .tap      (tap_q[i])
            );
        end
        else
        begin : g_link
            hds_tap_cell u_cell (
                .clk      (clk),
                .ctl      (tap_ctl[i]),
                .seed_pix (first_pix_reg[~ybit]),
                .nbr_pix  (tap_q[i-1]),
                .tap      (tap_q[i])
            );
        end
    end

    assign ctr_pix  = tap_q[0];
    assign left_pix = tap_q[NUM_TAPS-1];

    // Diffuse the center pixel and saturate
    always_comb
    begin
        nsum  = {2'b00, up_pix} + {2'b00, s1_pix_reg} + {2'b00, left_pix} + {2'b00, right_pix};
        lap   = signed'({1'b0, nsum}) - signed'({1'b0, ctr_pix, 2'b00});
        lap_x = VAL_W'(lap);
        term  = (gain_reg[0] ? lap_x : '0) + (gain_reg[1] ? (lap_x <<< 1) : '0);
        val   = VAL_W'(signed'({1'b0, ctr_pix})) + term;
        if (val[VAL_W-1])
        begin
            sat_pix = '0;
        end
        else if (val[VAL_W-2:PIX_W] != '0)
        begin
            sat_pix = '1;
        end
        else
        begin
            sat_pix = val[PIX_W-1:0];
        end
    end

    // Hand results to the output register, interior first
    assign o_free   = !o_valid_reg || out_ready;
    assign s1_any   = s1_pend_int_reg || s1_pend_bord_reg;
    assign move     = o_free && s1_any;
    assign in_ready = !s1_any || (move && !(s1_pend_int_reg && s1_pend_bord_reg));

    // Track pending results of the stencil stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_pend_int_reg  <= 1'b0;
            s1_pend_bord_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_pend_int_reg  <= int_en;
            s1_pend_bord_reg <= bord_en;
        end
        else if (move)
        begin
            if (s1_pend_int_reg)
            begin
                s1_pend_int_reg <= 1'b0;
            end
            else
            begin
                s1_pend_bord_reg <= 1'b0;
            end
        end
    end

    // Capture the item's position and pixel
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_row_reg  <= y;
            s1_col_reg  <= col_ext[COL_W-1:0];
            s1_pix_reg  <= pixel_in;
            s1_ybit_reg <= ybit;
            s1_done_reg <= last_row && last_col;
        end
    end

    // Hold a result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            if (s1_pend_int_reg)
            begin
                o_row_reg  <= s1_row_reg - ROW_W'(1);
                o_col_reg  <= s1_col_reg;
                o_pix_reg  <= sat_pix;
                o_last_reg <= !s1_pend_bord_reg;
                o_done_reg <= 1'b0;
            end
            else
            begin
                o_row_reg  <= s1_row_reg;
                o_col_reg  <= s1_col_reg;
                o_pix_reg  <= s1_pix_reg;
                o_last_reg <= 1'b1;
                o_done_reg <= s1_done_reg;
            end
        end
    end

    assign out_valid   = o_valid_reg;
    assign out_row     = o_row_reg;
    assign out_col     = o_col_reg;
    assign pixel_out   = o_pix_reg;
    assign last_of_run = o_last_reg;
    assign frame_done  = o_done_reg;

`ifndef SYNTHESIS
    // An interior result that is not last is followed at once by its border result
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_of_run) |=> (out_valid && last_of_run))
        else $error("border result did not follow interior result");

    // The bottom-right pixel closes its run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> last_of_run)
        else $error("frame_done without last_of_run");

    // A result that is not last is interior and never on the top row
    a_first_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_run) |-> ((out_row != '0) && !frame_done))
        else $error("non-last result outside the interior");
`endif

endmodule
